@@ rtl/atrt_pkg.sv @@
// ----------------------------------------------------------------------------
// atrt_pkg
// shared types and constants of the range-reduced arctangent core
// ----------------------------------------------------------------------------
package atrt_pkg;

   // working format: unsigned magnitudes with 30 fraction bits
   localparam int WORK_BITS = 30;
   localparam int A_W       = 44;   // reduced magnitude, holds 10000.0 in q.30
   localparam int REM_W     = 44;   // divider remainder and divisor
   localparam int SUM_W     = 32;   // series accumulator and final angle
   localparam int OPERAND_W = 32;
   localparam int ANGLE_W   = 18;
   localparam int RSP_TDATA_W = 24;
   localparam int RECIP_SHIFT = 35; // reciprocal scale for the term divides

   localparam logic [A_W-1:0] Q_ONE       = 44'd1073741824;
   localparam logic [A_W-1:0] Q_TWO       = 44'd2147483648;
   localparam logic [A_W-1:0] TAN_15DEG   = 44'd287708254;
   localparam logic [A_W-1:0] TAN_22P5DEG = 44'd444758426;

   localparam logic [SUM_W-1:0] PI_12 = 32'd281104952;
   localparam logic [SUM_W-1:0] PI_8  = 32'd421657428;
   localparam logic [SUM_W-1:0] PI_4  = 32'd843314857;
   localparam logic [SUM_W-1:0] PI_2  = 32'd1686629713;

   typedef enum logic [2:0] {
      SEG_DIRECT,
      SEG_PI12,
      SEG_PI8,
      SEG_PI4,
      SEG_RECIP
   } atrt_seg_type;

   typedef struct packed {
      logic         neg;
      atrt_seg_type seg;
      logic         sub;  // reciprocal above tan(pi/12), second split taken
   } atrt_tag_type;

   typedef struct packed {
      atrt_tag_type          tag;
      logic [WORK_BITS-1:0]  v;
   } atrt_div_side_type;

endpackage

@@ rtl/atrt_div.sv @@
// ----------------------------------------------------------------------------
// atrt_div
// pipelined restoring divider, one quotient bit per stage, q = x * 2^30 / d
// ----------------------------------------------------------------------------
module atrt_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  logic [atrt_pkg::REM_W-1:0]     in_x,     // must be below in_d
   input  logic [atrt_pkg::REM_W-1:0]     in_d,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_vld,
   output logic [atrt_pkg::WORK_BITS-1:0] out_q,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int QB = atrt_pkg::WORK_BITS;
   localparam int RW = atrt_pkg::REM_W;

   logic          vld_ff  [1:QB];
   logic [RW-1:0] rem_ff  [1:QB];
   logic [RW-1:0] d_ff    [1:QB];
   logic [QB-1:0] q_ff    [1:QB];
   logic [SIDE_W-1:0] side_ff [1:QB];

   genvar i;
   generate
      for (i = 1; i <= QB; i++) begin : g_stage
         logic              src_vld;
         logic [RW-1:0]     src_rem;
         logic [RW-1:0]     src_d;
         logic [QB-1:0]     src_q;
         logic [SIDE_W-1:0] src_side;
         logic [RW:0]       rem2;
         logic              ge;
         logic [RW-1:0]     rem_in;

         if (i == 1) begin : g_first
            assign src_vld  = in_vld;
            assign src_rem  = in_x;
            assign src_d    = in_d;
            assign src_q    = '0;
            assign src_side = in_side;
         end else begin : g_next
            assign src_vld  = vld_ff[i-1];
            assign src_rem  = rem_ff[i-1];
            assign src_d    = d_ff[i-1];
            assign src_q    = q_ff[i-1];
            assign src_side = side_ff[i-1];
         end

         // shift in a zero numerator bit, subtract when it fits
         assign rem2   = {src_rem, 1'b0};
         assign ge     = (rem2 >= {1'b0, src_d});
         assign rem_in = ge ? RW'(rem2 - {1'b0, src_d}) : rem2[RW-1:0];

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (en) begin
               vld_ff[i] <= src_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i]  <= rem_in;
               d_ff[i]    <= src_d;
               q_ff[i]    <= {src_q[QB-2:0], ge};
               side_ff[i] <= src_side;
            end
         end
      end
   endgenerate

   assign out_vld  = vld_ff[QB];
   assign out_q    = q_ff[QB];
   assign out_side = side_ff[QB];

endmodule

@@ rtl/atrt_series.sv @@
// ----------------------------------------------------------------------------
// atrt_series
// odd taylor series of atan, one power and one term divide per stage
// ----------------------------------------------------------------------------
module atrt_series #(
   parameter int SERIES_ORDER = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_vld,
   input  logic [atrt_pkg::WORK_BITS-1:0] in_v,
   input  logic [atrt_pkg::WORK_BITS-1:0] in_sq,
   input  atrt_pkg::atrt_tag_type         in_tag,
   output logic                           out_vld,
   output logic [atrt_pkg::SUM_W-1:0]     out_sum,
   output atrt_pkg::atrt_tag_type         out_tag
);

   localparam int WB    = atrt_pkg::WORK_BITS;
   localparam int SW    = atrt_pkg::SUM_W;
   localparam int RS    = atrt_pkg::RECIP_SHIFT;
   localparam int TERMS = (SERIES_ORDER - 1) / 2;
   localparam int NSTG  = TERMS + 2;

   logic          vld_ff  [1:NSTG];
   logic [WB-1:0] mag_ff  [1:NSTG];
   logic [WB-1:0] sq_ff   [1:NSTG];
   logic [WB-1:0] term_ff [1:NSTG];
   logic [SW-1:0] sum_ff  [1:NSTG];
   atrt_pkg::atrt_tag_type tag_ff [1:NSTG];

   genvar s;
   generate
      for (s = 1; s <= NSTG; s++) begin : g_stage
         // term computed here, and the earlier term folded into the sum here
         localparam int  KNOW    = s - 1;
         localparam int  KPREV   = s - 2;
         localparam bit  HAS     = (KNOW >= 1) && (KNOW <= TERMS);
         localparam bit  SUBPREV = (KPREV >= 1) && ((KPREV % 2) == 1);
         localparam longint unsigned Div = 2 * KNOW + 1;
         localparam logic [63:0] Recip = HAS ? (((64'd1 << RS) + Div - 1) / Div) : 64'd0;

         logic          src_vld;
         logic [WB-1:0] src_mag;
         logic [WB-1:0] src_sq;
         logic [WB-1:0] src_term;
         logic [SW-1:0] src_sum;
         atrt_pkg::atrt_tag_type src_tag;
         logic [2*WB-1:0] pow;
         logic [63:0]     prod;

         if (s == 1) begin : g_first
            assign src_vld  = in_vld;
            assign src_mag  = in_v;
            assign src_sq   = in_sq;
            assign src_term = '0;
            assign src_sum  = SW'(in_v);
            assign src_tag  = in_tag;
         end else begin : g_next
            assign src_vld  = vld_ff[s-1];
            assign src_mag  = mag_ff[s-1];
            assign src_sq   = sq_ff[s-1];
            assign src_term = term_ff[s-1];
            assign src_sum  = sum_ff[s-1];
            assign src_tag  = tag_ff[s-1];
         end

         assign pow  = (2*WB)'(src_mag) * (2*WB)'(src_sq);
         // exact floor divide by an odd constant via scaled reciprocal
         assign prod = 64'(src_mag) * Recip;

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (en) begin
               vld_ff[s] <= src_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               mag_ff[s]  <= pow[2*WB-1:WB];
               sq_ff[s]   <= src_sq;
               term_ff[s] <= HAS ? WB'(prod[63:RS]) : '0;
               sum_ff[s]  <= SUBPREV ? (src_sum - SW'(src_term))
                                     : (src_sum + SW'(src_term));
               tag_ff[s]  <= src_tag;
            end
         end
      end
   endgenerate

   assign out_vld = vld_ff[NSTG];
   assign out_sum = sum_ff[NSTG];
   assign out_tag = tag_ff[NSTG];

endmodule

@@ rtl/arctangent_range_reduced_taylor_core.sv @@
// throughput: one beat per cycle while rsp is not stalled; the two 30-stage
//   dividers and the series stages are fully pipelined, and one new operand
//   can enter every cycle that the pipeline advances
// the whole pipeline advances when the rsp register is empty or being taken
// reset (synchronous, active high) clears every valid bit; data regs keep junk
// ----------------------------------------------------------------------------
// arctangent_range_reduced_taylor_core
// signed q16.16 arctangent: saturate, range-reduce, divide, taylor series
// ----------------------------------------------------------------------------
module arctangent_range_reduced_taylor_core #(
   parameter int SERIES_ORDER  = 13,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [17:0] angle, [23:18] zero
);

   localparam int WB = atrt_pkg::WORK_BITS;
   localparam int AW = atrt_pkg::A_W;
   localparam int SW = atrt_pkg::SUM_W;
   localparam int SH = WB - FRACTION_BITS;
   localparam logic [AW-1:0] SAT_LIMIT = AW'(64'd10000 << FRACTION_BITS);
   localparam logic [SW-1:0] HALF_LSB  = SW'(64'd1 << (SH - 1));
   localparam int SIDE_W = $bits(atrt_pkg::atrt_div_side_type);

   // global advance: stall everything only when the result is held
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- stage 1: sign, magnitude, saturation, segment ----------
   logic                      s1_vld_ff;
   logic                      s1_neg_ff;
   logic [AW-1:0]             s1_a_ff;
   atrt_pkg::atrt_seg_type    s1_seg_ff;

   logic                      neg_in;
   logic [31:0]               mag_in;
   logic [AW-1:0]             mag_sat;
   logic [AW-1:0]             a_in;
   atrt_pkg::atrt_seg_type    seg_in;

   always_comb begin
      neg_in  = req_tdata[31];
      mag_in  = neg_in ? (~req_tdata + 32'd1) : req_tdata;  // -2^31 gives 2^31
      mag_sat = (AW'(mag_in) > SAT_LIMIT) ? SAT_LIMIT : AW'(mag_in);
      a_in    = mag_sat << SH;
      // a bound value stays in the lower segment
      if (a_in <= atrt_pkg::TAN_15DEG) begin
         seg_in = atrt_pkg::SEG_DIRECT;
      end else if (a_in <= atrt_pkg::TAN_22P5DEG) begin
         seg_in = atrt_pkg::SEG_PI12;
      end else if (a_in <= atrt_pkg::Q_ONE) begin
         seg_in = atrt_pkg::SEG_PI8;
      end else if (a_in <= atrt_pkg::Q_TWO) begin
         seg_in = atrt_pkg::SEG_PI4;
      end else begin
         seg_in = atrt_pkg::SEG_RECIP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_neg_ff <= neg_in;
         s1_a_ff   <= a_in;
         s1_seg_ff <= seg_in;
      end
   end

   // ---------------- stage 2: numerator and divisor of the first divide ------
   logic                           s2_vld_ff;
   logic [AW-1:0]                  s2_x_ff;
   logic [AW-1:0]                  s2_d_ff;
   atrt_pkg::atrt_div_side_type    s2_side_ff;

   logic [AW-1:0]                  tsel;
   logic [59:0]                    at_prod;
   logic [AW-1:0]                  x_in;
   logic [AW-1:0]                  d_in;
   atrt_pkg::atrt_div_side_type    side1_in;

   always_comb begin
      tsel    = (s1_seg_ff == atrt_pkg::SEG_PI8) ? atrt_pkg::TAN_22P5DEG : atrt_pkg::TAN_15DEG;
      at_prod = 60'(s1_a_ff[30:0]) * 60'(tsel[28:0]);
      case (s1_seg_ff)
         atrt_pkg::SEG_PI12, atrt_pkg::SEG_PI8: begin
            // (a - t) / (1 + a*t)
            x_in = s1_a_ff - tsel;
            d_in = atrt_pkg::Q_ONE + AW'(at_prod[59:30]);
         end
         atrt_pkg::SEG_PI4: begin
            x_in = s1_a_ff - atrt_pkg::Q_ONE;
            d_in = s1_a_ff + atrt_pkg::Q_ONE;
         end
         atrt_pkg::SEG_RECIP: begin
            x_in = atrt_pkg::Q_ONE;
            d_in = s1_a_ff;
         end
         default: begin
            x_in = '0;
            d_in = atrt_pkg::Q_ONE;
         end
      endcase
      side1_in.tag.neg = s1_neg_ff;
      side1_in.tag.seg = s1_seg_ff;
      side1_in.tag.sub = 1'b0;
      side1_in.v       = s1_a_ff[WB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ff    <= x_in;
         s2_d_ff    <= d_in;
         s2_side_ff <= side1_in;
      end
   end

   // ---------------- first divider ----------------
   logic                        dv1_vld;
   logic [WB-1:0]               dv1_q;
   logic [SIDE_W-1:0]           dv1_side_raw;
   atrt_pkg::atrt_div_side_type dv1_side;

   atrt_div #(
      .SIDE_W (SIDE_W)
   ) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s2_vld_ff),
      .in_x     (s2_x_ff),
      .in_d     (s2_d_ff),
      .in_side  (s2_side_ff),
      .out_vld  (dv1_vld),
      .out_q    (dv1_q),
      .out_side (dv1_side_raw)
   );

   assign dv1_side = atrt_pkg::atrt_div_side_type'(dv1_side_raw);

   // ---------------- stage 3: second split of the reciprocal ----------------
   logic                        s3_vld_ff;
   logic [AW-1:0]               s3_x_ff;
   logic [AW-1:0]               s3_d_ff;
   atrt_pkg::atrt_div_side_type s3_side_ff;

   logic                        sub_in;
   logic [59:0]                 it_prod;
   logic [AW-1:0]               x2_in;
   logic [AW-1:0]               d2_in;
   atrt_pkg::atrt_div_side_type side2_in;

   always_comb begin
      // reciprocal equal to tan(pi/12) takes the plain series
      sub_in  = (dv1_side.tag.seg == atrt_pkg::SEG_RECIP) &&
                (dv1_q > atrt_pkg::TAN_15DEG[WB-1:0]);
      it_prod = 60'(dv1_q) * 60'(atrt_pkg::TAN_15DEG[28:0]);
      x2_in   = sub_in ? AW'(dv1_q - atrt_pkg::TAN_15DEG[WB-1:0]) : '0;
      d2_in   = atrt_pkg::Q_ONE + AW'(it_prod[59:30]);
      side2_in.tag.neg = dv1_side.tag.neg;
      side2_in.tag.seg = dv1_side.tag.seg;
      side2_in.tag.sub = sub_in;
      side2_in.v       = (dv1_side.tag.seg == atrt_pkg::SEG_DIRECT) ? dv1_side.v : dv1_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= dv1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_x_ff    <= x2_in;
         s3_d_ff    <= d2_in;
         s3_side_ff <= side2_in;
      end
   end

   // ---------------- second divider ----------------
   logic                        dv2_vld;
   logic [WB-1:0]               dv2_q;
   logic [SIDE_W-1:0]           dv2_side_raw;
   atrt_pkg::atrt_div_side_type dv2_side;

   atrt_div #(
      .SIDE_W (SIDE_W)
   ) u_div2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s3_vld_ff),
      .in_x     (s3_x_ff),
      .in_d     (s3_d_ff),
      .in_side  (s3_side_ff),
      .out_vld  (dv2_vld),
      .out_q    (dv2_q),
      .out_side (dv2_side_raw)
   );

   assign dv2_side = atrt_pkg::atrt_div_side_type'(dv2_side_raw);

   // ---------------- stage 4: series argument and its square ----------------
   logic                   s4_vld_ff;
   logic [WB-1:0]          s4_v_ff;
   logic [WB-1:0]          s4_sq_ff;
   atrt_pkg::atrt_tag_type s4_tag_ff;

   logic [WB-1:0]          v_in;
   logic [2*WB-1:0]        vsq;

   assign v_in = dv2_side.tag.sub ? dv2_q : dv2_side.v;
   assign vsq  = (2*WB)'(v_in) * (2*WB)'(v_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= dv2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_v_ff   <= v_in;
         s4_sq_ff  <= vsq[2*WB-1:WB];
         s4_tag_ff <= dv2_side.tag;
      end
   end

   // ---------------- series ----------------
   logic                   ser_vld;
   logic [SW-1:0]          ser_sum;
   atrt_pkg::atrt_tag_type ser_tag;

   atrt_series #(
      .SERIES_ORDER (SERIES_ORDER)
   ) u_series (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (s4_vld_ff),
      .in_v    (s4_v_ff),
      .in_sq   (s4_sq_ff),
      .in_tag  (s4_tag_ff),
      .out_vld (ser_vld),
      .out_sum (ser_sum),
      .out_tag (ser_tag)
   );

   // ---------------- stage t1: add the segment offset ----------------
   logic          t1_vld_ff;
   logic          t1_neg_ff;
   logic [SW-1:0] t1_r_ff;

   logic [SW-1:0] base;
   logic          minus;
   logic [SW-1:0] r_in;

   always_comb begin
      case (ser_tag.seg)
         atrt_pkg::SEG_PI12: begin
            base  = atrt_pkg::PI_12;
            minus = 1'b0;
         end
         atrt_pkg::SEG_PI8: begin
            base  = atrt_pkg::PI_8;
            minus = 1'b0;
         end
         atrt_pkg::SEG_PI4: begin
            base  = atrt_pkg::PI_4;
            minus = 1'b0;
         end
         atrt_pkg::SEG_RECIP: begin
            // pi/2 - atan(1/a), with the pi/12 offset folded in
            base  = ser_tag.sub ? (atrt_pkg::PI_2 - atrt_pkg::PI_12) : atrt_pkg::PI_2;
            minus = 1'b1;
         end
         default: begin
            base  = '0;
            minus = 1'b0;
         end
      endcase
      r_in = minus ? (base - ser_sum) : (base + ser_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
      end else if (en) begin
         t1_vld_ff <= ser_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_neg_ff <= ser_tag.neg;
         t1_r_ff   <= r_in;
      end
   end

   // ---------------- output register: round half up, apply sign ------------
   logic                            rsp_vld_ff;
   logic [atrt_pkg::ANGLE_W-1:0]    angle_ff;

   logic [SW-1:0] rnd;
   logic [SW-1:0] signed_res;

   assign rnd        = (t1_r_ff + HALF_LSB) >> SH;
   assign signed_res = t1_neg_ff ? (~rnd + 32'd1) : rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= t1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= signed_res[atrt_pkg::ANGLE_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(atrt_pkg::RSP_TDATA_W - atrt_pkg::ANGLE_W){1'b0}}, angle_ff};

`ifndef SYNTHESIS
   // first divide never overflows the 30-bit quotient
   a_div1_fits: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (s2_x_ff < s2_d_ff))
      else $error("first divide numerator not below divisor");

   // second divide never overflows the 30-bit quotient
   a_div2_fits: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (s3_x_ff < s3_d_ff))
      else $error("second divide numerator not below divisor");

   // reciprocal branch subtracts no more than its offset
   a_recip_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (ser_vld && (ser_tag.seg == atrt_pkg::SEG_RECIP)) |-> (ser_sum <= base))
      else $error("series sum exceeds reciprocal offset");

   // second split only happens on the reciprocal segment
   a_sub_only_recip: assert property (@(posedge clock) disable iff (reset)
      (s3_vld_ff && s3_side_ff.tag.sub) |-> (s3_side_ff.tag.seg == atrt_pkg::SEG_RECIP))
      else $error("second split outside reciprocal segment");
`endif

endmodule

@@ tb/sv/atrt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrt_checker
// watches the req and rsp streams, predicts each angle and compares it
// ----------------------------------------------------------------------------
module atrt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          angles_pending
);

   localparam int ORDER = 13;
   localparam int FRAC  = 16;
   localparam int WBITS = atrt_pkg::WORK_BITS;
   localparam logic [63:0] SAT_MAG = 64'd10000 << FRAC;
   localparam logic [63:0] ONE     = 64'(atrt_pkg::Q_ONE);
   localparam logic [63:0] TWO     = 64'(atrt_pkg::Q_TWO);
   localparam logic [63:0] T15     = 64'(atrt_pkg::TAN_15DEG);
   localparam logic [63:0] T22     = 64'(atrt_pkg::TAN_22P5DEG);

   logic [23:0] angle_queue[$];

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      p = a * b;
      return p >> WBITS;
   endfunction

   function automatic logic [63:0] taylor_atan(logic [63:0] v);
      logic [63:0] sq, term, acc;
      logic minus;
      sq = qmul(v, v);
      term = v;
      acc = v;
      minus = 1'b1;
      for (int k = 3; k <= ORDER; k += 2) begin
         term = qmul(term, sq);
         if (minus) acc = acc - term / k;
         else acc = acc + term / k;
         minus = !minus;
      end
      return acc;
   endfunction

   function automatic logic [63:0] offset_arg(logic [63:0] a, logic [63:0] t);
      return ((a - t) << WBITS) / (ONE + qmul(a, t));
   endfunction

   function automatic logic [23:0] predict_angle(logic [31:0] operand);
      logic neg;
      logic [63:0] mag, a, r, inv, res;
      neg = operand[31];
      mag = neg ? (64'd1 << 32) - 64'(operand) : 64'(operand);
      if (mag > SAT_MAG) mag = SAT_MAG;
      a = mag << (WBITS - FRAC);
      if (a <= T15) r = taylor_atan(a);
      else if (a <= T22)
         r = 64'(atrt_pkg::PI_12) + taylor_atan(offset_arg(a, T15));
      else if (a <= ONE)
         r = 64'(atrt_pkg::PI_8) + taylor_atan(offset_arg(a, T22));
      else if (a <= TWO)
         r = 64'(atrt_pkg::PI_4) + taylor_atan(((a - ONE) << WBITS) / (a + ONE));
      else begin
         inv = (ONE << WBITS) / a;
         if (inv > T15)
            r = 64'(atrt_pkg::PI_2) - 64'(atrt_pkg::PI_12)
                - taylor_atan(offset_arg(inv, T15));
         else r = 64'(atrt_pkg::PI_2) - taylor_atan(inv);
      end
      res = (r + (64'd1 << (WBITS - FRAC - 1))) >> (WBITS - FRAC);
      if (neg) res = 64'd0 - res;
      return {6'd0, res[17:0]};
   endfunction

   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         fail_count <= 0;
         angles_pending <= 0;
         angle_queue.delete();
      end else begin
         if (req_tvalid && req_tready) angle_queue.push_back(predict_angle(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected rsp beat, expected none, actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: angle mismatch, expected %h, actual %h", $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         angles_pending <= angle_queue.size();
      end
   end
endmodule

@@ tb/sv/tb_arctangent_range_reduced_taylor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arctangent_range_reduced_taylor_core
// drives operands with random gaps and rsp stalls; the checker scores angles
// ----------------------------------------------------------------------------
module tb_arctangent_range_reduced_taylor_core;
   localparam int RANDOM_BEATS = 1430;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] operand
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [17:0] angle, [23:18] zero
   int          fail_count;
   int          angles_pending;
   int          send_idle_pct = 18;  // percent of cycles the sender idles
   int          recv_idle_pct = 65;  // percent of cycles the receiver stalls
   bit          hold_off = 1'b0;     // long rsp stall to back the pipe up
   longint      cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   arctangent_range_reduced_taylor_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   atrt_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .angles_pending(angles_pending)
   );

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stalls, or held off entirely during the pressure window
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one beat: optional idle cycles, then hold valid until taken
   task automatic send_operand(input logic [31:0] operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= operand;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // magnitudes near the segment bounds, in ranges up to 10000, plus full-range noise
   function automatic logic [31:0] random_operand();
      logic [31:0] m;
      case ($urandom_range(5))
         0: m = $urandom();
         1: m = $urandom_range(32'h0001_0000);        // 0..1
         2: m = $urandom_range(32'h0003_0000);        // 0..3
         3: m = $urandom_range(32'h2710_0000);        // 0..10000
         4: m = $urandom_range(32'h0000_7000, 32'h0000_4000); // near tan(pi/12), tan(pi/8)
         default: m = $urandom_range(32'h0002_2000, 32'h0001_e000);
      endcase
      if (m[31] == 1'b0 && $urandom_range(1)) m = -m;
      return m;
   endfunction

   initial begin
      logic [31:0] directed[$];
      directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0001, 32'h2710_0000, 32'h2710_0001,
                   32'hD8F0_0000, 32'hD8EF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                   32'h0002_0000, 32'hFFFE_0000, 32'h0001_0001, 32'h0002_0001,
                   32'h0000_4498, 32'h0000_4499, 32'h0000_6A09, 32'h0000_6A0A,
                   32'h0003_BB67, 32'h0003_BB68, 32'h0000_FFFF, 32'hAAAA_5555,
                   32'h5555_AAAA};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_operand(directed[i]);
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 18;
         end
         if (i == 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // pressure window: receiver stalls while the sender keeps offering
         if (i == RANDOM_BEATS / 2) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         send_operand(random_operand());
      end
      req_tvalid <= 1'b0;
      recv_idle_pct = 0;
      while (angles_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && angles_pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
